// ===== sv/hsl_pkg.sv =====
// Package for the HSL to RGB converter: fixed field widths and channel limits.
// No dependencies; imported by hsl_to_rgb_converter_top, hsl_pixel_checker and testbench.
package hsl_pkg;

   localparam int HUE_W = 12;   // hue field width
   localparam int SL_W  = 13;   // saturation and lightness field width
   localparam int CH_W  = 8;    // colour channel width

   localparam logic [CH_W-1:0] CH_MAX = 8'd255;

   localparam int NUM_CH = 3;   // red, green, blue

   typedef logic [CH_W-1:0] channel_type;

endpackage

// ===== sv/hsl_to_rgb_converter_top.sv =====
// HSL to RGB pixel converter, four register stages.
// A beat taken with start passes the stage 1 to 4 registers to the rsp_ ports, shown there for one cycle.
// Throughput: one pixel per clock; busy stays low, as the receiver cannot stall.
// The per-channel hue-weight multipliers in stage three set the depth of each stage.
// Reset clears the valid bits of every stage; payload registers are not reset.
// Depends on hsl_pkg.
module hsl_to_rgb_converter_top
   import hsl_pkg::*;
#(
   parameter int FRAC_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [SL_W-1:0]   req_saturation,
   input  logic [SL_W-1:0]   req_lightness,
   output logic              rsp_valid,
   output channel_type       rsp_red,
   output channel_type       rsp_green,
   output channel_type       rsp_blue
);

   localparam int F   = FRAC_BITS;
   localparam int XW  = (F > HUE_W) ? F : HUE_W;
   localparam int SX  = (F + 1 > SL_W) ? F + 1 : SL_W;
   localparam int PW  = 3 * F + 1;

   localparam logic [SX-1:0]  UNIT_SX = SX'(1) << F;
   localparam logic [F:0]     UNIT_L  = (F + 1)'(1) << F;
   localparam logic [F+1:0]   ONE_T   = (F + 2)'(1) << F;
   localparam logic [F+1:0]   TWO_T   = (F + 2)'(2) << F;
   localparam logic [F+1:0]   THREE_T = (F + 2)'(3) << F;
   localparam logic [F+2:0]   ONE_W   = (F + 3)'(1) << F;
   localparam logic [F+2:0]   THREE_W = (F + 3)'(3) << F;
   localparam logic [F+2:0]   FOUR_W  = (F + 3)'(4) << F;
   localparam logic [F+1:0]   TWO_TW  = (F + 2)'(2) << F;

   // Piecewise hue weight in [0, 1.0]; t3 is the hue offset in thirds of a turn.
   function automatic logic [F:0] ramp_weight(input logic [F+1:0] t3);
      logic [F+2:0] t2;
      logic [F+2:0] down;
      t2   = {t3, 1'b0};
      down = FOUR_W - t2;
      if (t2 < ONE_W) begin
         return t2[F:0];
      end else if (t2 < THREE_W) begin
         return UNIT_L;
      end else if (t3 < TWO_TW) begin
         return down[F:0];
      end else begin
         return '0;
      end
   endfunction

   // Stage 1: normalise fields, half-lightness distance, hue offsets
   logic              v1_ff, v1_in;
   logic [F:0]        s1_ff, s1_in;
   logic [F:0]        l1_ff, l1_in;
   logic [F-1:0]      a1_ff, a1_in;
   logic [F+1:0]      t1_ff [NUM_CH];
   logic [F+1:0]      t1_in [NUM_CH];

   logic [XW-1:0]     hue_x;
   logic [F-1:0]      hue_n;
   logic [SX-1:0]     sat_x;
   logic [SX-1:0]     lit_x;
   logic [F+1:0]      h3;
   logic [F+1:0]      tr_raw;
   logic [F:0]        upper_gap;

   always_comb begin
      hue_x  = XW'(req_hue);
      hue_n  = hue_x[F-1:0];
      sat_x  = SX'(req_saturation);
      lit_x  = SX'(req_lightness);
      v1_in  = start;
      s1_in  = (sat_x > UNIT_SX) ? UNIT_L : sat_x[F:0];
      l1_in  = (lit_x > UNIT_SX) ? UNIT_L : lit_x[F:0];
      upper_gap = UNIT_L - l1_in;
      // below one half the spread follows l, above it follows 1 - l
      a1_in  = (l1_in[F:F-1] == 2'b00) ? l1_in[F-1:0] : upper_gap[F-1:0];
      h3     = (F + 2)'(hue_n) + ((F + 2)'(hue_n) << 1);
      tr_raw = h3 + ONE_T;
      t1_in[0] = (tr_raw >= THREE_T) ? tr_raw - THREE_T : tr_raw;
      t1_in[1] = h3;
      t1_in[2] = (h3 >= ONE_T) ? h3 - ONE_T : h3 + TWO_T;
   end

   // Stage 2: spread product m = s * a, channel weights
   logic              v2_ff, v2_in;
   logic [F:0]        l2_ff, l2_in;
   logic [2*F-1:0]    m2_ff, m2_in;
   logic [F:0]        w2_ff [NUM_CH];
   logic [F:0]        w2_in [NUM_CH];
   logic [2*F:0]      m2_full;

   always_comb begin
      v2_in   = v1_ff;
      l2_in   = l1_ff;
      m2_full = (2 * F + 1)'(s1_ff) * (2 * F + 1)'(a1_ff);
      m2_in   = m2_full[2*F-1:0];
      for (int c = 0; c < NUM_CH; c++) begin
         w2_in[c] = ramp_weight(t1_ff[c]);
      end
   end

   // Stage 3: channel products m * w and base p = l - m
   logic              v3_ff, v3_in;
   logic [2*F:0]      p3_ff, p3_in;
   logic [3*F-1:0]    pr3_ff [NUM_CH];
   logic [3*F-1:0]    pr3_in [NUM_CH];
   logic [3*F:0]      pr3_full [NUM_CH];

   always_comb begin
      v3_in = v2_ff;
      p3_in = {l2_ff, {F{1'b0}}} - (2 * F + 1)'(m2_ff);
      for (int c = 0; c < NUM_CH; c++) begin
         pr3_full[c] = PW'(m2_ff) * PW'(w2_ff[c]);
         pr3_in[c]   = pr3_full[c][3*F-1:0];
      end
   end

   // Stage 4: channel value p + 2*m*w, scale to 8 bits and saturate
   logic              v4_ff, v4_in;
   channel_type       ch4_ff [NUM_CH];
   channel_type       ch4_in [NUM_CH];
   logic [PW-1:0]     sum4 [NUM_CH];
   logic [CH_W:0]     top4 [NUM_CH];

   always_comb begin
      v4_in = v3_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         sum4[c]   = {p3_ff, {F{1'b0}}} + {pr3_ff[c], 1'b0};
         top4[c]   = sum4[c][PW-1:PW-CH_W-1];
         ch4_in[c] = top4[c][CH_W] ? CH_MAX : top4[c][CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      l1_ff <= l1_in;
      a1_ff <= a1_in;
      l2_ff <= l2_in;
      m2_ff <= m2_in;
      p3_ff <= p3_in;
      for (int c = 0; c < NUM_CH; c++) begin
         t1_ff[c]  <= t1_in[c];
         w2_ff[c]  <= w2_in[c];
         pr3_ff[c] <= pr3_in[c];
         ch4_ff[c] <= ch4_in[c];
      end
   end

   assign busy      = 1'b0;
   assign rsp_valid = v4_ff;
   assign rsp_red   = ch4_ff[0];
   assign rsp_green = ch4_ff[1];
   assign rsp_blue  = ch4_ff[2];

endmodule

// ===== bench/hsl_pixel_checker.sv =====
`timescale 1ns / 1ps
// Checker for the HSL to RGB converter: predicts every pixel taken on the req_ side
// and compares each rsp_ beat against the oldest prediction. Depends on hsl_pkg.
module hsl_pixel_checker
   import hsl_pkg::*;
#(
   parameter int FRAC_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [SL_W-1:0]   req_saturation,
   input  logic [SL_W-1:0]   req_lightness,
   input  logic              rsp_valid,
   input  channel_type       rsp_red,
   input  channel_type       rsp_green,
   input  channel_type       rsp_blue,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      channel_type red;
      channel_type green;
      channel_type blue;
   } rgb_pixel_type;

   localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;

   rgb_pixel_type rgb_q[$];
   int            errors = 0;

   function automatic logic [63:0] clamp_unit(logic [63:0] v);
      return (v > UNIT) ? UNIT : v;
   endfunction

   // p2 and d2 carry 2*FRAC_BITS fraction bits; hue position t3 is in thirds of a turn
   function automatic channel_type shade(logic [63:0] p2, logic [63:0] d2,
                                         logic [63:0] t3);
      logic [63:0] v3;
      logic [63:0] level;
      if (64'd2 * t3 < UNIT)
         v3 = p2 * UNIT + d2 * (64'd2 * t3);
      else if (64'd2 * t3 < 64'd3 * UNIT)
         v3 = (p2 + d2) * UNIT;
      else if (t3 < 64'd2 * UNIT)
         v3 = p2 * UNIT + d2 * (64'd4 * UNIT - 64'd2 * t3);
      else
         v3 = p2 * UNIT;
      level = v3 >> (3 * FRAC_BITS - CH_W);
      return (level > 64'(CH_MAX)) ? CH_MAX : level[CH_W-1:0];
   endfunction

   function automatic rgb_pixel_type hsl_to_rgb(logic [HUE_W-1:0] hue,
                                                logic [SL_W-1:0] sat,
                                                logic [SL_W-1:0] lig);
      logic [63:0]   h, s, l, q2, p2, d2, h3, t_red, t_blue;
      rgb_pixel_type px;
      h = 64'(hue) & (UNIT - 64'd1);
      s = clamp_unit(64'(sat));
      l = clamp_unit(64'(lig));
      if (64'd2 * l < UNIT)
         q2 = l * (UNIT + s);
      else
         q2 = l * UNIT + s * UNIT - l * s;
      p2 = 64'd2 * l * UNIT - q2;
      d2 = q2 - p2;
      // offset hue by plus and minus one third, wrapped modulo one turn
      h3 = 64'd3 * h;
      t_red = h3 + UNIT;
      if (t_red >= 64'd3 * UNIT)
         t_red = t_red - 64'd3 * UNIT;
      t_blue = (h3 >= UNIT) ? h3 - UNIT : h3 + 64'd2 * UNIT;
      px.red   = shade(p2, d2, t_red);
      px.green = shade(p2, d2, h3);
      px.blue  = shade(p2, d2, t_blue);
      return px;
   endfunction

   always @(posedge clock) begin
      rgb_pixel_type want;
      if (reset) begin
         rgb_q.delete();
      end else begin
         if (start && busy !== 1'b1)
            rgb_q.push_back(hsl_to_rgb(req_hue, req_saturation, req_lightness));
         if (rsp_valid) begin
            if (rgb_q.size() == 0) begin
               $error("rsp beat with no pixel outstanding");
               errors++;
            end else begin
               want = rgb_q.pop_front();
               if (rsp_red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_red);
                  errors++;
               end
               if (rsp_green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_green);
                  errors++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
                  errors++;
               end
            end
         end
      end
      pending    <= rgb_q.size();
      fail_count <= errors;
   end

   final begin
      if (rgb_q.size() != 0)
         $error("%0d pixels never answered", rgb_q.size());
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the HSL to RGB converter bench: drives pixels with random gaps and gives the
// verdict. Depends on hsl_pkg, hsl_to_rgb_converter_top and hsl_pixel_checker.
module testbench;
   import hsl_pkg::*;

   localparam int FRAC_BITS    = 12;
   localparam int RANDOM_BEATS = 1500;
   localparam int MAX_CYCLES   = 200000;
   localparam int TAIL_CYCLES  = 12;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [HUE_W-1:0]  req_hue;
   logic [SL_W-1:0]   req_saturation;
   logic [SL_W-1:0]   req_lightness;
   logic              rsp_valid;
   channel_type       rsp_red;
   channel_type       rsp_green;
   channel_type       rsp_blue;
   int                fail_count;
   int                pending;
   int                cycle_count = 0;
   bit                back_to_back = 0;

   hsl_to_rgb_converter_top #(.FRAC_BITS(FRAC_BITS)) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   hsl_pixel_checker #(.FRAC_BITS(FRAC_BITS)) u_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Hold start high until the beat is taken; idle for a random gap first.
   task automatic send_pixel(logic [HUE_W-1:0] h, logic [SL_W-1:0] s,
                             logic [SL_W-1:0] l);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_hue        <= h;
      req_saturation <= s;
      req_lightness  <= l;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every pixel sent has come back.
   task automatic drain_pixels();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Mostly in-range fractions, with some above 1.0 and some extremes.
   function automatic logic [SL_W-1:0] draw_fraction();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            return SL_W'($urandom_range(4097, 8191));
         end
         1: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return SL_W'(2048);
               default: return SL_W'(4096);
            endcase
         end
         default: begin
            return SL_W'($urandom_range(0, 4096));
         end
      endcase
   endfunction

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_hue        <= '0;
      req_saturation <= '0;
      req_lightness  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // greys from zero saturation
      send_pixel(12'd0,    13'd0,    13'd0);
      send_pixel(12'd4095, 13'd0,    13'd4096);
      send_pixel(12'd1000, 13'd0,    13'd2048);
      // pure hues at full saturation: channel of exactly 1.0 and sector edges
      send_pixel(12'd0,    13'd4096, 13'd2048);
      send_pixel(12'd682,  13'd4096, 13'd2048);
      send_pixel(12'd683,  13'd4096, 13'd2048);
      send_pixel(12'd1365, 13'd4096, 13'd2048);
      send_pixel(12'd1366, 13'd4096, 13'd2048);
      send_pixel(12'd2048, 13'd4096, 13'd2048);
      send_pixel(12'd2730, 13'd4096, 13'd2048);
      send_pixel(12'd2731, 13'd4096, 13'd2048);
      send_pixel(12'd4095, 13'd4096, 13'd2048);
      // just below and exactly at half lightness
      send_pixel(12'd500,  13'd3000, 13'd2047);
      send_pixel(12'd500,  13'd3000, 13'd2048);
      // saturation and lightness above 1.0
      send_pixel(12'd300,  13'd8191, 13'd8191);
      send_pixel(12'd3000, 13'd4097, 13'd4097);
      send_pixel(12'd100,  13'd8191, 13'd1000);
      send_pixel(12'd4095, 13'd8191, 13'd0);
      // black and white
      send_pixel(12'd4095, 13'd4096, 13'd4096);
      send_pixel(12'd0,    13'd4096, 13'd0);
      // alternating bit patterns
      send_pixel(12'haaa,  13'h0aaa, 13'h1555);
      send_pixel(12'h555,  13'h1555, 13'h0aaa);
      drain_pixels();

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 64 == 0)
            back_to_back = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_BEATS / 2)
            drain_pixels();
         send_pixel(HUE_W'($urandom_range(0, 4095)), draw_fraction(), draw_fraction());
      end
      drain_pixels();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
